>>> rtl/core/pmpu_pkg.sv
package pmpu_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_SQ,
		ST_SQRT,
		ST_NORM,
		ST_CORDIC,
		ST_RED,
		ST_FIN
	} pmpu_state_t;

	localparam int CORDIC_STEPS = 24;
	localparam logic signed [34:0] DEG180 = 35'sd11796480;
	localparam logic signed [34:0] DEG360 = 35'sd23592960;
	localparam logic signed [34:0] DEG360_X128 = 35'sd3019898880;
	localparam logic signed [32:0] Z90_Q24 = 33'sd1509949440;
	localparam logic [31:0] DEG90_Q16 = 32'd5898240;

	localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
		32'd754974720, 32'd445687602, 32'd235489088, 32'd119537938,
		32'd60000934, 32'd30029717, 32'd15018523, 32'd7509719,
		32'd3754917, 32'd1877466, 32'd938734, 32'd469367,
		32'd234684, 32'd117342, 32'd58671, 32'd29335,
		32'd14668, 32'd7334, 32'd3667, 32'd1833,
		32'd917, 32'd458, 32'd229, 32'd115
	};

endpackage

>>> rtl/core/polar_magnitude_phase_unwrap.sv
// Converts one coefficient pair per beat to magnitude and phase in degrees, unwrapping the
// phase against the previous phase of its frequency slot unless the term is DC, the component
// index is zero or the slot is out of range. One item is processed at a time. A pair passes
// through an idle state, bit-serial product accumulation, bit-serial squaring, digit-by-digit
// square root, normalizing shifts, 24 CORDIC vectoring iterations, phase reduction and an
// output state. A DC term passes only the idle state, the products and the output state. The
// result sits in an output register, and a new input beat is taken once the previous result
// has been loaded; a stalled full output register holds the unit in its output state.
module polar_magnitude_phase_unwrap
	import pmpu_pkg::*;
#(
	parameter int NUM_FREQ = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               polar_fourier_mode,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] coef_re,
	input  logic signed [31:0] coef_im,
	input  logic        [31:0] norm_re,
	input  logic        [31:0] norm_im,
	input  logic        [3:0]  comp_index,
	input  logic        [2:0]  freq_index,
	output logic               out_valid,
	input  logic               out_stall,
	output logic        [31:0] magnitude,
	output logic signed [31:0] phase_deg,
	output logic        [3:0]  out_comp,
	output logic        [2:0]  out_freq
);

	localparam int FW = (NUM_FREQ > 1) ? $clog2(NUM_FREQ) : 1;

	pmpu_state_t state_q, state_d;

	logic mode_q;
	logic dc_q, re_neg_q, im_neg_q;
	logic [3:0] comp_q;
	logic [2:0] freq_q;
	logic [5:0] cnt_q;
	logic [63:0] mca_q, mcb_q, pa_q, pb_q, x_q, y_q;
	logic [31:0] mpa_q, mpb_q;
	logic [64:0] sq_q;
	logic sat_q;
	logic [65:0] rad_q;
	logic [36:0] rem_q;
	logic [32:0] root_q;
	logic signed [32:0] cx_q, cy_q, z_q;
	logic signed [34:0] v_q;
	logic signed [31:0] prev_phase_q [NUM_FREQ];

	logic in_fire, out_free, slot_ok, unwrap;
	logic [FW-1:0] slot;
	logic [36:0] rem_n, trial;
	logic signed [32:0] shx, shy, zc;
	logic [31:0] ang;
	logic signed [34:0] base, r, d, tot, sub;
	logic signed [31:0] ref_ph, phase_fin;
	logic [31:0] mag_fin;
	logic [31:0] are, aim;

	assign cfg_ready = 1'b1;
	assign in_fire = in_valid && !in_stall;
	assign out_free = !out_valid || !out_stall;
	assign slot = FW'(freq_q);
	assign slot_ok = 32'(freq_q) < 32'(NUM_FREQ);
	assign unwrap = !dc_q && comp_q != 4'd0 && slot_ok;
	assign ref_ph = prev_phase_q[slot];
	assign are = coef_re[31] ? 32'(-coef_re) : 32'(coef_re);
	assign aim = coef_im[31] ? 32'(-coef_im) : 32'(coef_im);

	always_comb begin
		rem_n = {rem_q[34:0], rad_q[65:64]};
		trial = {2'b00, root_q, 2'b01};
		shx = cx_q >>> cnt_q[4:0];
		shy = cy_q >>> cnt_q[4:0];
		sub = DEG360 <<< cnt_q[3:0];
		if (z_q[32]) begin
			zc = '0;
		end else if (z_q > Z90_Q24) begin
			zc = Z90_Q24;
		end else begin
			zc = z_q;
		end
		if (pb_q == 64'd0) begin
			ang = '0;
		end else if (pa_q == 64'd0) begin
			ang = DEG90_Q16;
		end else begin
			ang = 32'((zc + 33'sd128) >>> 8);
		end
		if (!(re_neg_q && pa_q != 64'd0)) begin
			base = 35'(ang);
		end else begin
			base = DEG180 - 35'(ang);
		end
		if (im_neg_q && pb_q != 64'd0) begin
			base = -base;
		end
		r = v_q - DEG180;
		d = base - r;
		if (d > DEG180) begin
			d = d - DEG360;
		end else if (d < -DEG180) begin
			d = d + DEG360;
		end
		tot = 35'(ref_ph) + d;
		if (dc_q) begin
			phase_fin = re_neg_q ? 32'(DEG180) : 32'sd0;
			mag_fin = (pa_q[63:48] != 16'd0) ? 32'hFFFF_FFFF : pa_q[47:16];
		end else begin
			mag_fin = (sat_q || root_q[32]) ? 32'hFFFF_FFFF : root_q[31:0];
			if (!unwrap) begin
				phase_fin = 32'(base);
			end else if (tot > 35'sd2147483647) begin
				phase_fin = 32'sh7FFF_FFFF;
			end else if (tot < -35'sd2147483648) begin
				phase_fin = 32'sh8000_0000;
			end else begin
				phase_fin = 32'(tot);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				if (cnt_q == 6'd31) begin
					state_d = dc_q ? ST_FIN : ST_SQ;
				end
			end
			ST_SQ: begin
				if (cnt_q == 6'd31) begin
					state_d = ST_SQRT;
				end
			end
			ST_SQRT: begin
				if (cnt_q == 6'd33) begin
					state_d = ST_NORM;
				end
			end
			ST_NORM: begin
				if ((x_q | y_q) < 64'h4000_0000) begin
					state_d = ST_CORDIC;
				end
			end
			ST_CORDIC: begin
				if (cnt_q == 6'(CORDIC_STEPS - 1)) begin
					state_d = ST_RED;
				end
			end
			ST_RED: begin
				if (cnt_q == 6'd0) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			out_valid <= 1'b0;
			for (int i = 0; i < NUM_FREQ; i++) begin
				prev_phase_q[i] <= '0;
			end
		end else begin
			if (cfg_valid) begin
				mode_q <= polar_fourier_mode;
			end
			if (state_q == ST_FIN && out_free) begin
				out_valid <= 1'b1;
				if (slot_ok) begin
					prev_phase_q[slot] <= phase_fin;
				end
			end else if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					dc_q <= mode_q && freq_index == 3'd0;
					re_neg_q <= coef_re[31];
					im_neg_q <= coef_im[31];
					comp_q <= comp_index;
					freq_q <= freq_index;
					mca_q <= {32'd0, are};
					mcb_q <= {32'd0, aim};
					mpa_q <= norm_re;
					mpb_q <= norm_im;
					pa_q <= '0;
					pb_q <= '0;
					cnt_q <= '0;
				end
			end
			ST_MUL: begin
				if (mpa_q[0]) begin
					pa_q <= pa_q + mca_q;
				end
				if (mpb_q[0]) begin
					pb_q <= pb_q + mcb_q;
				end
				mca_q <= mca_q << 1;
				mcb_q <= mcb_q << 1;
				mpa_q <= mpa_q >> 1;
				mpb_q <= mpb_q >> 1;
				if (cnt_q == 6'd31) begin
					cnt_q <= '0;
				end else begin
					cnt_q <= cnt_q + 6'd1;
				end
			end
			ST_SQ: begin
				if (cnt_q == 6'd0) begin
					sat_q <= pa_q[63:48] != 16'd0 || pb_q[63:48] != 16'd0;
					mca_q <= {32'd0, pa_q[47:16]};
					mcb_q <= {32'd0, pb_q[47:16]};
					mpa_q <= pa_q[47:16];
					mpb_q <= pb_q[47:16];
					sq_q <= '0;
				end else begin
					sq_q <= sq_q + (mpa_q[0] ? {1'b0, mca_q} : 65'd0)
						+ (mpb_q[0] ? {1'b0, mcb_q} : 65'd0);
					mca_q <= mca_q << 1;
					mcb_q <= mcb_q << 1;
					mpa_q <= mpa_q >> 1;
					mpb_q <= mpb_q >> 1;
				end
				if (cnt_q == 6'd31) begin
					cnt_q <= '0;
				end else begin
					cnt_q <= cnt_q + 6'd1;
				end
			end
			ST_SQRT: begin
				if (cnt_q == 6'd0) begin
					sq_q <= sq_q + (mpa_q[0] ? {1'b0, mca_q} : 65'd0)
						+ (mpb_q[0] ? {1'b0, mcb_q} : 65'd0);
					rad_q <= {1'b0, sq_q + (mpa_q[0] ? {1'b0, mca_q} : 65'd0)
						+ (mpb_q[0] ? {1'b0, mcb_q} : 65'd0)};
					rem_q <= '0;
					root_q <= '0;
					cnt_q <= 6'd1;
				end else begin
					rad_q <= rad_q << 2;
					if (rem_n >= trial) begin
						rem_q <= rem_n - trial;
						root_q <= {root_q[31:0], 1'b1};
					end else begin
						rem_q <= rem_n;
						root_q <= {root_q[31:0], 1'b0};
					end
					if (cnt_q == 6'd33) begin
						cnt_q <= '0;
						x_q <= pa_q;
						y_q <= pb_q;
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
			end
			ST_NORM: begin
				if ((x_q | y_q) >= 64'h4000_0000) begin
					x_q <= x_q >> 1;
					y_q <= y_q >> 1;
				end else begin
					cx_q <= 33'(x_q[29:0]);
					cy_q <= 33'(y_q[29:0]);
					z_q <= '0;
					cnt_q <= '0;
				end
			end
			ST_CORDIC: begin
				if (!cy_q[32]) begin
					cx_q <= cx_q + shy;
					cy_q <= cy_q - shx;
					z_q <= z_q + 33'(ATAN_TAB[cnt_q[4:0]]);
				end else begin
					cx_q <= cx_q - shy;
					cy_q <= cy_q + shx;
					z_q <= z_q - 33'(ATAN_TAB[cnt_q[4:0]]);
				end
				if (cnt_q == 6'(CORDIC_STEPS - 1)) begin
					cnt_q <= 6'd9;
					v_q <= 35'(ref_ph) + DEG180;
				end else begin
					cnt_q <= cnt_q + 6'd1;
				end
			end
			ST_RED: begin
				if (cnt_q == 6'd9) begin
					if (v_q[34]) begin
						v_q <= v_q + DEG360_X128;
					end
					cnt_q <= 6'd8;
				end else begin
					if (v_q >= sub) begin
						v_q <= v_q - sub;
					end
					if (cnt_q != 6'd0) begin
						cnt_q <= cnt_q - 6'd1;
					end
				end
			end
			ST_FIN: begin
				if (out_free) begin
					magnitude <= mag_fin;
					phase_deg <= phase_fin;
					out_comp <= comp_q;
					out_freq <= freq_q;
				end
			end
			default: begin
				cnt_q <= '0;
			end
		endcase
	end

endmodule
